>>> src/b2b_pkg.sv
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared types, constants and the initial chain value of the BLAKE2b engine.
// ----------------------------------------------------------------------------
package b2b_pkg;

   typedef logic [63:0] word_type;
   typedef word_type [0:7] chain_type;
   typedef word_type [0:3] row_type;

   typedef struct packed {
      logic start;
      logic last;
   } eng_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_sts_type;

   localparam word_type IV [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [3:0] SIGMA [0:11][0:15] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
   };

   // 12 rounds x 8 mixes x 2 halves
   localparam logic [7:0] LAST_STEP = 8'd191;

   localparam logic [31:0] PARAM_BASE  = 32'h01010000;
   localparam logic [7:0]  BLOCK_BYTES = 8'd128;
   localparam logic [3:0]  LAST_WORD_POS = 4'd15;

   localparam logic [6:0]  DIGEST_LENGTH_RESET = 7'd50;
   localparam logic [31:0] PARAM_N_RESET       = 32'd200;
   localparam logic [31:0] PARAM_K_RESET       = 32'd9;
   localparam word_type    PERSONAL_RESET      = 64'h576f50687361635a;

   localparam logic [1:0] CSR_DIGEST_LENGTH = 2'd0;
   localparam logic [1:0] CSR_PARAM_N       = 2'd1;
   localparam logic [1:0] CSR_PARAM_K       = 2'd2;
   localparam logic [1:0] CSR_PERSONAL      = 2'd3;

   function automatic chain_type init_chain(input logic [6:0] dl, input logic [31:0] pn,
                                            input logic [31:0] pk, input word_type pers);
      chain_type h;
      for (int i = 0; i < 8; i++) begin
         h[i] = IV[i];
      end
      h[0] = h[0] ^ ({32'd0, PARAM_BASE} | {57'd0, dl});
      h[6] = h[6] ^ pers;
      h[7] = h[7] ^ {pk, pn};
      return h;
   endfunction

endpackage

>>> src/b2b_req_if.sv
// ----------------------------------------------------------------------------
// b2b_req_if
// Message word channel: one 64-bit word per beat, count and flag on word 16.
// ----------------------------------------------------------------------------
interface b2b_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [7:0]  block_bytes;
   logic        final_block;

   modport source (output valid, message_word, block_bytes, final_block, input ready);
   modport sink   (input valid, message_word, block_bytes, final_block, output ready);
endinterface

>>> src/b2b_rsp_if.sv
// ----------------------------------------------------------------------------
// b2b_rsp_if
// Digest channel: one 64-bit digest word per beat.
// ----------------------------------------------------------------------------
interface b2b_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> src/b2b_msg_buf.sv
// ----------------------------------------------------------------------------
// b2b_msg_buf
// Sixteen-word message block store, one write and one registered read port.
// ----------------------------------------------------------------------------
module b2b_msg_buf (
   input  logic               clock,
   input  logic               we,
   input  logic [3:0]         waddr,
   input  b2b_pkg::word_type  wdata,
   input  logic [3:0]         raddr,
   output b2b_pkg::word_type  rdata
);
   import b2b_pkg::*;

   word_type mem_ff [0:15];
   word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/b2b_mix.sv
// ----------------------------------------------------------------------------
// b2b_mix
// One half of the G function: two dependent adds, xors and rotates.
// ----------------------------------------------------------------------------
module b2b_mix (
   input  b2b_pkg::word_type a,
   input  b2b_pkg::word_type b,
   input  b2b_pkg::word_type c,
   input  b2b_pkg::word_type d,
   input  b2b_pkg::word_type x,
   input  logic              second,
   output b2b_pkg::word_type a_out,
   output b2b_pkg::word_type b_out,
   output b2b_pkg::word_type c_out,
   output b2b_pkg::word_type d_out
);
   import b2b_pkg::*;

   word_type sum_a;
   word_type dx;
   word_type d_rot;
   word_type sum_c;
   word_type bx;

   assign sum_a = a + b + x;
   assign dx    = d ^ sum_a;
   assign d_rot = second ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
   assign sum_c = c + d_rot;
   assign bx    = b ^ sum_c;

   assign a_out = sum_a;
   assign d_out = d_rot;
   assign c_out = sum_c;
   assign b_out = second ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};

endmodule

>>> src/b2b_engine.sv
// ----------------------------------------------------------------------------
// b2b_engine
// Compression sequencer: 4x4 working state in rotating rows, one half-G a cycle.
// ----------------------------------------------------------------------------
module b2b_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  b2b_pkg::eng_cmd_type  cmd,
   input  b2b_pkg::chain_type    chain,
   input  b2b_pkg::word_type     count,
   input  b2b_pkg::word_type     msg_word,
   output logic [3:0]            msg_addr,
   output b2b_pkg::eng_sts_type  sts,
   output b2b_pkg::chain_type    fold
);
   import b2b_pkg::*;

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_MIX  = 2'd1;
   localparam logic [1:0] E_FOLD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [7:0] step_ff, step_in;
   logic [7:0] next_step;
   row_type    v_ff [0:3];
   row_type    v_in [0:3];
   row_type    w    [0:3];

   logic     diag;
   logic     second;
   word_type mix_b, mix_c, mix_d;
   word_type new_a, new_b, new_c, new_d;

   assign diag   = step_ff[3];
   assign second = step_ff[0];

   assign mix_b = diag ? v_ff[1][1] : v_ff[1][0];
   assign mix_c = diag ? v_ff[2][2] : v_ff[2][0];
   assign mix_d = diag ? v_ff[3][3] : v_ff[3][0];

   b2b_mix u_mix (
      .a      (v_ff[0][0]),
      .b      (mix_b),
      .c      (mix_c),
      .d      (mix_d),
      .x      (msg_word),
      .second (second),
      .a_out  (new_a),
      .b_out  (new_b),
      .c_out  (new_c),
      .d_out  (new_d)
   );

   assign next_step = (state_ff == E_MIX && step_ff != LAST_STEP) ? step_ff + 8'd1 : 8'd0;
   assign msg_addr  = SIGMA[next_step[7:4]][next_step[3:0]];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         w[r] = v_ff[r];
      end
      w[0][0] = new_a;
      if (diag) begin
         w[1][1] = new_b;
         w[2][2] = new_c;
         w[3][3] = new_d;
      end else begin
         w[1][0] = new_b;
         w[2][0] = new_c;
         w[3][0] = new_d;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         v_in[r] = v_ff[r];
      end
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               for (int k = 0; k < 4; k++) begin
                  v_in[0][k] = chain[k];
                  v_in[1][k] = chain[k + 4];
                  v_in[2][k] = IV[k];
                  v_in[3][k] = IV[k + 4];
               end
               v_in[3][0] = IV[4] ^ count;
               if (cmd.last) begin
                  v_in[3][2] = ~IV[6];
               end
               step_in  = 8'd0;
               state_in = E_MIX;
            end
         end
         E_MIX: begin
            for (int r = 0; r < 4; r++) begin
               for (int k = 0; k < 4; k++) begin
                  v_in[r][k] = second ? w[r][2'(k + 1)] : w[r][k];
               end
            end
            step_in = step_ff + 8'd1;
            if (step_ff == LAST_STEP) begin
               state_in = E_FOLD;
            end
         end
         E_FOLD: begin
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         step_ff  <= 8'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 4; r++) begin
         v_ff[r] <= v_in[r];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         fold[k]     = v_ff[0][k] ^ v_ff[2][k];
         fold[k + 4] = v_ff[1][k] ^ v_ff[3][k];
      end
   end

   assign sts.busy = (state_ff != E_IDLE);
   assign sts.done = (state_ff == E_FOLD);

endmodule

>>> src/blake2b_block_hash.sv
// ----------------------------------------------------------------------------
// blake2b_block_hash
// BLAKE2b engine with configurable digest length, personal and parameter words.
// ----------------------------------------------------------------------------
// Words 1 to 15 of a block take one cycle each; word 16 starts a compression
// (a load, 192 half-G steps on the single mix unit, a fold), during which the
// message port is not ready. After a final block the digest words go out one
// per beat, at most 8, then the chain value re-initialises.
// Reset (synchronous) restores the register defaults and the initial chain value.
// ----------------------------------------------------------------------------
module blake2b_block_hash (
   input  logic        clock,
   input  logic        reset,
   b2b_req_if.sink     req,
   b2b_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import b2b_pkg::*;

   localparam logic [1:0] S_FILL = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [6:0] dl_ff, dl_in;
   logic [31:0] pn_ff, pn_in;
   logic [31:0] pk_ff, pk_in;
   word_type   pers_ff, pers_in;
   chain_type  chain_ff, chain_in;
   word_type   count_ff, count_in;
   logic [3:0] wpos_ff, wpos_in;
   logic [2:0] idx_ff, idx_in;
   logic       start_ff, start_in;
   logic       last_ff, last_in;

   logic        cfg_we;
   logic [1:0]  cfg_idx;
   chain_type   init;
   logic [7:0]  dl_round;
   logic [4:0]  words_raw;
   logic [3:0]  nwords;
   logic        rsp_last;
   logic        req_beat;
   logic        rsp_beat;
   logic [7:0]  nbytes;

   eng_cmd_type eng_cmd;
   eng_sts_type eng_sts;
   chain_type   fold;
   logic [3:0]  msg_addr;
   word_type    msg_word;

   assign cfg_we     = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx    = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   always_comb begin
      case (cfg_idx)
         CSR_DIGEST_LENGTH: csr_prdata = {57'd0, dl_ff};
         CSR_PARAM_N:       csr_prdata = {32'd0, pn_ff};
         CSR_PARAM_K:       csr_prdata = {32'd0, pk_ff};
         CSR_PERSONAL:      csr_prdata = pers_ff;
         default:           csr_prdata = 64'd0;
      endcase
   end

   always_comb begin
      dl_in   = dl_ff;
      pn_in   = pn_ff;
      pk_in   = pk_ff;
      pers_in = pers_ff;
      if (cfg_we) begin
         case (cfg_idx)
            CSR_DIGEST_LENGTH: dl_in   = csr_pwdata[6:0];
            CSR_PARAM_N:       pn_in   = csr_pwdata[31:0];
            CSR_PARAM_K:       pk_in   = csr_pwdata[31:0];
            CSR_PERSONAL:      pers_in = csr_pwdata;
            default:           dl_in   = dl_ff;
         endcase
      end
   end

   assign init      = init_chain(dl_in, pn_in, pk_in, pers_in);
   assign dl_round  = {1'b0, dl_ff} + 8'd7;
   assign words_raw = dl_round[7:3];
   assign nwords    = (words_raw > 5'd8) ? 4'd8 : words_raw[3:0];
   assign rsp_last  = ({1'b0, idx_ff} == nwords - 4'd1);
   assign nbytes    = (req.block_bytes > BLOCK_BYTES) ? BLOCK_BYTES : req.block_bytes;

   assign req.ready = (state_ff == S_FILL);
   assign req_beat  = req.valid & req.ready;
   assign rsp_beat  = rsp.valid & rsp.ready;

   assign rsp.valid       = (state_ff == S_EMIT);
   assign rsp.digest_word = chain_ff[idx_ff];
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = rsp_last;

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      wpos_in  = wpos_ff;
      idx_in   = idx_ff;
      start_in = 1'b0;
      last_in  = last_ff;
      case (state_ff)
         S_FILL: begin
            if (req_beat) begin
               if (wpos_ff == LAST_WORD_POS) begin
                  wpos_in  = 4'd0;
                  count_in = count_ff + {56'd0, nbytes};
                  last_in  = req.final_block;
                  start_in = 1'b1;
                  state_in = S_RUN;
               end else begin
                  wpos_in = wpos_ff + 4'd1;
               end
            end
         end
         S_RUN: begin
            if (eng_sts.done) begin
               for (int i = 0; i < 8; i++) begin
                  chain_in[i] = chain_ff[i] ^ fold[i];
               end
               state_in = S_FILL;
               if (last_ff) begin
                  idx_in = 3'd0;
                  if (nwords == 4'd0) begin
                     chain_in = init;
                     count_in = 64'd0;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_EMIT: begin
            if (rsp_beat) begin
               if (rsp_last) begin
                  chain_in = init;
                  count_in = 64'd0;
                  wpos_in  = 4'd0;
                  state_in = S_FILL;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_FILL;
         end
      endcase
      if (cfg_we) begin
         chain_in = init;
         count_in = 64'd0;
         wpos_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
         dl_ff    <= DIGEST_LENGTH_RESET;
         pn_ff    <= PARAM_N_RESET;
         pk_ff    <= PARAM_K_RESET;
         pers_ff  <= PERSONAL_RESET;
         chain_ff <= init_chain(DIGEST_LENGTH_RESET, PARAM_N_RESET, PARAM_K_RESET,
                                PERSONAL_RESET);
         count_ff <= 64'd0;
         wpos_ff  <= 4'd0;
         idx_ff   <= 3'd0;
         start_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dl_ff    <= dl_in;
         pn_ff    <= pn_in;
         pk_ff    <= pk_in;
         pers_ff  <= pers_in;
         chain_ff <= chain_in;
         count_ff <= count_in;
         wpos_ff  <= wpos_in;
         idx_ff   <= idx_in;
         start_ff <= start_in;
         last_ff  <= last_in;
      end
   end

   assign eng_cmd.start = start_ff;
   assign eng_cmd.last  = last_ff;

   b2b_msg_buf u_msg_buf (
      .clock (clock),
      .we    (req_beat),
      .waddr (wpos_ff),
      .wdata (req.message_word),
      .raddr (msg_addr),
      .rdata (msg_word)
   );

   b2b_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd      (eng_cmd),
      .chain    (chain_ff),
      .count    (count_ff),
      .msg_word (msg_word),
      .msg_addr (msg_addr),
      .sts      (eng_sts),
      .fold     (fold)
   );

   a_ready_not_busy: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && eng_sts.busy))
      else $error("message port ready while compression runs");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      eng_sts.done |-> (state_ff == S_RUN))
      else $error("compression finished outside run state");

   a_reinit_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_word) |=>
         (count_ff == 64'd0 && wpos_ff == 4'd0 && req.ready))
      else $error("engine not re-initialised after last digest beat");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_word) |=>
         (rsp.valid && rsp.word_index == 3'($past(rsp.word_index) + 3'd1)))
      else $error("digest word index did not advance");

endmodule
